FILE: src/tcfu_pkg.sv
// Shared types, constants and helpers for the trigger cell frame unpacker.
// Self-contained; used by the top level, the output stage and the testbench.
`default_nettype none

package tcfu_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAMES_TO_SKIP   = 3'd0,
    REG_CHANNELS_TO_SKIP = 3'd1,
    REG_LAT_HIGH_OCC     = 3'd2,
    REG_LAT_LOW_OCC      = 3'd3,
    REG_LAT_SUPER_CELL   = 3'd4
  } reg_index_t;

  // Reset values of the configuration registers
  localparam logic [3:0] FRAMES_TO_SKIP_RST   = 4'd2;
  localparam logic [6:0] CHANNELS_TO_SKIP_RST = 7'd4;
  localparam logic [7:0] LAT_HIGH_OCC_RST     = 8'd10;
  localparam logic [7:0] LAT_LOW_OCC_RST      = 8'd4;
  localparam logic [7:0] LAT_SUPER_CELL_RST   = 8'd12;

  localparam int CELLS = 4;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Module slot within a channel pair
  typedef enum logic [2:0] {
    SLOT_HIGH_OCC  = 3'd0,
    SLOT_LOW_OCC   = 3'd1,
    SLOT_SUPER_A   = 3'd2,
    SLOT_SUPER_B   = 3'd3,
    SLOT_SUPER_ODD = 3'd4
  } slot_t;

  // Link idle patterns
  localparam int NUM_IDLE = 7;
  localparam logic [NUM_IDLE-1:0][63:0] IDLE_WORDS = {
    64'h8000040082008000,
    64'd4400227581952,
    64'd864699926762782720,
    64'd4096,
    64'd1008819510838298624,
    64'd432349964455149568,
    64'h0000000000000000
  };

  typedef struct packed {
    logic       ok;
    logic [2:0] col;
  } col_t;

  // One decoded frame waiting to be sent out cell by cell
  typedef struct packed {
    logic [CELLS-1:0]         mask;
    logic [CELLS-1:0][14:0]   cells;
    logic [CELLS-1:0][2:0]    cols;
    logic [8:0]               module_res;
    logic [12:0]              crossing_in;
    logic [12:0]              crossing_out;
  } frame_t;

  function automatic col_t cell_column(input slot_t slot, input logic [1:0] k,
                                       input logic [2:0] phase);
    col_t       r;
    logic [5:0] sum;
    sum = 6'(k) + {1'b0, phase, 2'b00} - 6'd2;
    if (slot == SLOT_HIGH_OCC) begin
      if (phase == 3'd0) begin
        r.ok  = 1'b1;
        r.col = {2'b00, k[1]};
      end else begin
        r.ok  = (sum <= 6'd6);
        r.col = sum[2:0];
      end
    end else begin
      r.col = {1'b0, k};
      r.ok  = !(((slot == SLOT_SUPER_B) || (slot == SLOT_SUPER_ODD)) && (k == 2'd3));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/tcfu_count_ram.sv
// Per-channel frame counter memory: one read and one write port, registered read.
// Per-entry valid bits make unwritten entries read as zero; depends on nothing else.
`default_nettype none

module tcfu_count_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data,
  output logic      [15:0]   rd_data
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [15:0]      rd_q;
  logic             rd_vld;
  logic             fwd;
  logic [15:0]      fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      fwd    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
        // write to the same entry in the read cycle: take the new value
        fwd    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd ? fwd_data : (rd_vld ? rd_q : 16'd0);

endmodule

`default_nettype wire

FILE: src/tcfu_cell_emit.sv
// Output stage: holds one decoded frame and sends its trigger cells one per word.
// Depends on tcfu_pkg for the frame type.
`default_nettype none

module tcfu_cell_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire tcfu_pkg::frame_t frame,
  output logic                 ready,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [8:0]           module_res,
  output logic [2:0]           column,
  output logic [8:0]           energy,
  output logic [5:0]           cell_address,
  output logic [12:0]          crossing_in,
  output logic [12:0]          crossing_out,
  output logic                 last
);

  tcfu_pkg::frame_t cur;
  logic [3:0]       mask;
  logic [3:0]       pick;
  logic [1:0]       idx;
  logic             take;

  // lowest pending cell goes first
  always_comb begin
    idx  = 2'd0;
    pick = 4'd0;
    for (int i = tcfu_pkg::CELLS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx  = 2'(i);
        pick = 4'd1 << i;
      end
    end
  end

  assign out_valid    = |mask;
  assign last         = ((mask & ~pick) == 4'd0);
  assign take         = out_valid && !out_stall;
  assign ready        = !out_valid || (take && last);
  assign module_res   = cur.module_res;
  assign column       = cur.cols[idx];
  assign energy       = cur.cells[idx][8:0];
  assign cell_address = cur.cells[idx][14:9];
  assign crossing_in  = cur.crossing_in;
  assign crossing_out = cur.crossing_out;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'd0;
    end else if (load) begin
      mask <= frame.mask;
    end else if (take) begin
      mask <= mask & ~pick;
    end
  end

endmodule

`default_nettype wire

FILE: src/trigger_cell_frame_unpacker.sv
// Trigger cell frame unpacker, top level. Uses tcfu_pkg, tcfu_count_ram, tcfu_cell_emit.
// Path: the frame word is registered on acceptance together with its counter read, then
// decoded into the output stage once that stage is ready, and its cells leave from there.
// Output: a frame that yields no cells retires without the output stage; a frame with n
// cells (max 4) holds the single output port until all n have left, one cell per word.
// Reset: synchronous; registers load their defaults and the counter valid bits clear at
// once, so all counters read zero with no clearing pass.
`default_nettype none

module trigger_cell_frame_unpacker #(
  parameter int NUM_CHANNELS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // frame input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [6:0]  channel,
  input  wire logic [63:0] frame_word,
  // cell output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [8:0]       module_res,
  output logic [2:0]       column,
  output logic [8:0]       energy,
  output logic [5:0]       cell_address,
  output logic [12:0]      crossing_in,
  output logic [12:0]      crossing_out,
  output logic             last
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers
  logic [3:0] frames_to_skip;
  logic [6:0] channels_to_skip;
  logic [7:0] lat_high_occ;
  logic [7:0] lat_low_occ;
  logic [7:0] lat_super_cell;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_skip   <= tcfu_pkg::FRAMES_TO_SKIP_RST;
      channels_to_skip <= tcfu_pkg::CHANNELS_TO_SKIP_RST;
      lat_high_occ     <= tcfu_pkg::LAT_HIGH_OCC_RST;
      lat_low_occ      <= tcfu_pkg::LAT_LOW_OCC_RST;
      lat_super_cell   <= tcfu_pkg::LAT_SUPER_CELL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tcfu_pkg::REG_FRAMES_TO_SKIP:   frames_to_skip   <= cfg_data[3:0];
        tcfu_pkg::REG_CHANNELS_TO_SKIP: channels_to_skip <= cfg_data[6:0];
        tcfu_pkg::REG_LAT_HIGH_OCC:     lat_high_occ     <= cfg_data;
        tcfu_pkg::REG_LAT_LOW_OCC:      lat_low_occ      <= cfg_data;
        tcfu_pkg::REG_LAT_SUPER_CELL:   lat_super_cell   <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Input accept and counter read. A channel outside the counter range is
  // taken off the link but dropped with no counter change.
  logic          in_acc;
  logic          in_range;
  logic          s1_valid;
  logic          s1_adv;
  logic          s1_has;
  logic [6:0]    s1_channel;
  logic [63:0]   s1_word;
  logic [15:0]   count;
  logic [15:0]   count_next;
  logic          emit_ready;

  assign in_range = (32'(channel) < NUM_CHANNELS);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Write back happens when the decode stage advances, which is also the only
  // edge at which the next word can read; the counter memory forwards that case.
  tcfu_count_ram #(
    .DEPTH (NUM_CHANNELS),
    .AW    (AW)
  ) u_count_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (AW'(channel)),
    .wr_en   (s1_adv),
    .wr_addr (AW'(s1_channel)),
    .wr_data (count_next),
    .rd_data (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_acc && in_range) || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_channel <= channel;
      s1_word    <= frame_word;
    end
  end

  // Saturate the counter at its maximum
  assign count_next = (count == tcfu_pkg::COUNT_MAX) ? count : count + 16'd1;

  // Decode stage
  logic              idle;
  logic              skip;
  logic [15:0]       diff;
  logic [2:0]        phase;
  logic [12:0]       xout;
  logic              slot_ok;
  tcfu_pkg::slot_t   slot;
  logic [7:0]        lat;
  logic              lat_ok;
  logic [6:0]        chan_off;
  logic [5:0]        pair;
  logic              go;
  tcfu_pkg::col_t    colr [tcfu_pkg::CELLS];
  tcfu_pkg::frame_t  frame;

  always_comb begin
    idle = 1'b0;
    for (int i = 0; i < tcfu_pkg::NUM_IDLE; i++) begin
      if (s1_word == tcfu_pkg::IDLE_WORDS[i]) begin
        idle = 1'b1;
      end
    end
  end

  assign skip  = idle || (count < 16'(frames_to_skip)) || (s1_channel < channels_to_skip);
  assign diff  = count - 16'(frames_to_skip);
  assign phase = diff[2:0];
  assign xout  = diff[15:3];

  // Pick the module slot from channel parity and phase
  always_comb begin
    slot_ok = 1'b1;
    slot    = tcfu_pkg::SLOT_HIGH_OCC;
    if (s1_channel[0]) begin
      slot    = tcfu_pkg::SLOT_SUPER_ODD;
      slot_ok = (phase == 3'd0);
    end else begin
      case (phase)
        3'd0, 3'd1, 3'd2: slot = tcfu_pkg::SLOT_HIGH_OCC;
        3'd3:             slot = tcfu_pkg::SLOT_LOW_OCC;
        3'd4:             slot = tcfu_pkg::SLOT_SUPER_A;
        3'd5:             slot = tcfu_pkg::SLOT_SUPER_B;
        default:          slot_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (slot)
      tcfu_pkg::SLOT_HIGH_OCC: lat = lat_high_occ;
      tcfu_pkg::SLOT_LOW_OCC:  lat = lat_low_occ;
      default:                 lat = lat_super_cell;
    endcase
  end

  assign lat_ok   = (xout >= 13'(lat));
  assign chan_off = s1_channel - channels_to_skip;
  assign pair     = chan_off[6:1];
  assign go       = !skip && slot_ok && lat_ok;

  always_comb begin
    for (int k = 0; k < tcfu_pkg::CELLS; k++) begin
      colr[k]          = tcfu_pkg::cell_column(slot, 2'(k), phase);
      frame.mask[k]    = go && colr[k].ok;
      frame.cols[k]    = colr[k].col;
      frame.cells[k]   = s1_word[16*k +: 15];
    end
    // pair * 5 + slot
    frame.module_res   = {1'b0, pair, 2'b00} + 9'(pair) + 9'(slot);
    frame.crossing_in  = xout - 13'(lat);
    frame.crossing_out = xout;
  end

  // A frame with no cells retires at once; otherwise wait for the output stage
  assign s1_has = |frame.mask;
  assign s1_adv = s1_valid && (!s1_has || emit_ready);

  tcfu_cell_emit u_cell_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (s1_adv && s1_has),
    .frame        (frame),
    .ready        (emit_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .module_res   (module_res),
    .column       (column),
    .energy       (energy),
    .cell_address (cell_address),
    .crossing_in  (crossing_in),
    .crossing_out (crossing_out),
    .last         (last)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Testbench for trigger_cell_frame_unpacker: frames go in with random gaps and cells
// come out under random stall; a cycle-free predictor checks every cell field by field.
// Depends on tcfu_pkg and the unpacker RTL.

module testbench;

  // Cycles with no word moved on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to wait after the last expected cell, covering frames that yield nothing
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_LINKS      = 128;

  typedef struct packed {
    logic [8:0]  module_res;
    logic [2:0]  column;
    logic [8:0]  energy;
    logic [5:0]  cell_address;
    logic [12:0] crossing_in;
    logic [12:0] crossing_out;
    logic        last;
  } trigger_cell_t;

  // Link idle patterns; a frame equal to one of these is never unpacked
  function automatic logic [63:0] idle_pattern(input int i);
    case (i)
      0: return 64'h0;
      1: return 64'd432349964455149568;
      2: return 64'd1008819510838298624;
      3: return 64'd4096;
      4: return 64'd864699926762782720;
      5: return 64'd4400227581952;
      default: return 64'h8000040082008000;
    endcase
  endfunction

  function automatic bit is_idle_word(input logic [63:0] word);
    for (int i = 0; i < 7; i++)
      if (word === idle_pattern(i)) return 1'b1;
    return 1'b0;
  endfunction

  // Expected-cell tracker: mirrors the per-channel frame counters and the registers,
  // turns each accepted frame into the cells it must produce, and checks the output.
  class trigger_cell_tracker;
    trigger_cell_t pending_cells[$];
    logic [15:0]   frame_count[NUM_LINKS];
    logic [3:0]    frames_to_skip;
    logic [6:0]    channels_to_skip;
    logic [7:0]    lat_high_occ;
    logic [7:0]    lat_low_occ;
    logic [7:0]    lat_super_cell;
    int            errors;
    int            frames_noted;
    int            cells_checked;

    function new();
      frames_to_skip   = tcfu_pkg::FRAMES_TO_SKIP_RST;
      channels_to_skip = tcfu_pkg::CHANNELS_TO_SKIP_RST;
      lat_high_occ     = tcfu_pkg::LAT_HIGH_OCC_RST;
      lat_low_occ      = tcfu_pkg::LAT_LOW_OCC_RST;
      lat_super_cell   = tcfu_pkg::LAT_SUPER_CELL_RST;
      foreach (frame_count[i]) frame_count[i] = '0;
      errors        = 0;
      frames_noted  = 0;
      cells_checked = 0;
    endfunction

    function void write_reg(input logic [2:0] index, input logic [7:0] data);
      case (index)
        tcfu_pkg::REG_FRAMES_TO_SKIP:   frames_to_skip   = data[3:0];
        tcfu_pkg::REG_CHANNELS_TO_SKIP: channels_to_skip = data[6:0];
        tcfu_pkg::REG_LAT_HIGH_OCC:     lat_high_occ     = data;
        tcfu_pkg::REG_LAT_LOW_OCC:      lat_low_occ      = data;
        tcfu_pkg::REG_LAT_SUPER_CELL:   lat_super_cell   = data;
        default: ;
      endcase
    endfunction

    // Column of cell k in a module; returns 0 when that cell is not emitted
    function bit column_of(input tcfu_pkg::slot_t slot, input int k,
                           input logic [2:0] phase, output int col);
      if (slot == tcfu_pkg::SLOT_HIGH_OCC) begin
        col = (phase == 3'd0) ? k / 2 : k + 4 * int'(phase) - 2;
        return col <= 6;
      end
      col = k;
      return !((slot == tcfu_pkg::SLOT_SUPER_B || slot == tcfu_pkg::SLOT_SUPER_ODD) &&
               k == 3);
    endfunction

    function void note_frame(input logic [6:0] ch, input logic [63:0] word);
      logic [15:0]     count;
      logic [15:0]     rel;
      logic [2:0]      phase;
      logic [12:0]     xout;
      logic [7:0]      lat;
      logic [6:0]      offset;
      tcfu_pkg::slot_t slot;
      bit              slot_ok;
      int              col;
      int              emit_total;
      int              emitted;
      trigger_cell_t   tc;
      frames_noted++;
      count = frame_count[ch];
      if (count != tcfu_pkg::COUNT_MAX) frame_count[ch] = count + 16'd1;
      if (is_idle_word(word)) return;
      if (count < 16'(frames_to_skip) || ch < channels_to_skip) return;
      rel   = count - 16'(frames_to_skip);
      phase = rel[2:0];
      xout  = rel[15:3];
      slot    = tcfu_pkg::SLOT_HIGH_OCC;
      slot_ok = 1'b1;
      if (ch[0]) begin
        if (phase == 3'd0) slot = tcfu_pkg::SLOT_SUPER_ODD;
        else slot_ok = 1'b0;
      end else begin
        case (phase)
          3'd0, 3'd1, 3'd2: slot = tcfu_pkg::SLOT_HIGH_OCC;
          3'd3: slot = tcfu_pkg::SLOT_LOW_OCC;
          3'd4: slot = tcfu_pkg::SLOT_SUPER_A;
          3'd5: slot = tcfu_pkg::SLOT_SUPER_B;
          default: slot_ok = 1'b0;
        endcase
      end
      if (!slot_ok) return;
      case (slot)
        tcfu_pkg::SLOT_HIGH_OCC: lat = lat_high_occ;
        tcfu_pkg::SLOT_LOW_OCC:  lat = lat_low_occ;
        default:                 lat = lat_super_cell;
      endcase
      if (xout < 13'(lat)) return;
      offset = ch - channels_to_skip;
      emit_total = 0;
      for (int k = 0; k < tcfu_pkg::CELLS; k++)
        if (column_of(slot, k, phase, col)) emit_total++;
      emitted = 0;
      for (int k = 0; k < tcfu_pkg::CELLS; k++) begin
        if (!column_of(slot, k, phase, col)) continue;
        tc.module_res   = 9'(int'(offset[6:1]) * 5 + int'(slot));
        tc.column       = 3'(col);
        tc.energy       = word[16*k +: 9];
        tc.cell_address = word[16*k+9 +: 6];
        tc.crossing_in  = xout - 13'(lat);
        tc.crossing_out = xout;
        tc.last         = (emitted == emit_total - 1);
        pending_cells.push_back(tc);
        emitted++;
      end
    endfunction

    function void check_field(input string name, input logic [12:0] want,
                              input logic [12:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_cell(input trigger_cell_t got);
      trigger_cell_t want;
      if (pending_cells.size() == 0) begin
        $error("cell with no frame behind it: module_res %0d column %0d",
               got.module_res, got.column);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      cells_checked++;
      check_field("module_res", want.module_res, got.module_res);
      check_field("column", want.column, got.column);
      check_field("energy", want.energy, got.energy);
      check_field("cell_address", want.cell_address, got.cell_address);
      check_field("crossing_in", want.crossing_in, got.crossing_in);
      check_field("crossing_out", want.crossing_out, got.crossing_out);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = tcfu_pkg::REG_FRAMES_TO_SKIP;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  channel = '0;
  logic [63:0] frame_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  module_res;
  logic [2:0]  column;
  logic [8:0]  energy;
  logic [5:0]  cell_address;
  logic [12:0] crossing_in;
  logic [12:0] crossing_out;
  logic        last;

  bit idle_enabled = 1'b1;    // random gaps and stalls allowed
  int stall_left = 0;
  int quiet_cycles = 0;
  int settings_used = 0;
  trigger_cell_tracker tracker;

  trigger_cell_frame_unpacker dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every cell word accepted at this edge against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_cell('{module_res, column, energy, cell_address,
                           crossing_in, crossing_out, last});
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles", quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one frame word, optionally after a random gap, and hold it until taken.
  // Leave in_valid high on return so back-to-back frames need no extra edge.
  task automatic send_frame(input logic [6:0] ch, input logic [63:0] word);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    channel    <= ch;
    frame_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_frame(ch, word);
  endtask

  // Drop valid, wait for every expected cell, then let frames with no cells flush out
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(index, data);
  endtask

  // Bring the block to idle, then load all five registers; optionally hit the
  // unused register indexes too, which must change nothing
  task automatic load_settings(input int fts, input int cts, input int lat_hi,
                               input int lat_lo, input int lat_sc, input bit poke_unused);
    settle();
    write_reg(tcfu_pkg::REG_FRAMES_TO_SKIP, 8'(fts));
    write_reg(tcfu_pkg::REG_CHANNELS_TO_SKIP, 8'(cts));
    write_reg(tcfu_pkg::REG_LAT_HIGH_OCC, 8'(lat_hi));
    write_reg(tcfu_pkg::REG_LAT_LOW_OCC, 8'(lat_lo));
    write_reg(tcfu_pkg::REG_LAT_SUPER_CELL, 8'(lat_sc));
    if (poke_unused)
      for (int idx = int'(tcfu_pkg::REG_LAT_SUPER_CELL) + 1; idx < 8; idx++)
        write_reg(3'(idx), 8'hFF);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Random frames, mostly on a narrow band of live channels so their counters climb
  // through every phase; the rest is noise on any channel and idle patterns
  task automatic random_phase(input int items, input bit pause_midway);
    int          lo_ch;
    int          hi_ch;
    logic [6:0]  ch;
    logic [63:0] word;
    lo_ch = tracker.channels_to_skip;
    hi_ch = (lo_ch + 3 > NUM_LINKS - 1) ? NUM_LINKS - 1 : lo_ch + 3;
    for (int i = 0; i < items; i++) begin
      // halfway through, if asked, hold off until every expected cell is out
      if (pause_midway && i == items / 2) settle();
      if ($urandom_range(0, 7) == 0) ch = 7'($urandom_range(0, NUM_LINKS - 1));
      else ch = 7'($urandom_range(lo_ch, hi_ch));
      case ($urandom_range(0, 9))
        0: word = idle_pattern($urandom_range(0, 6));
        1: word = 64'hFFFF_FFFF_FFFF_FFFF;
        2: word = {$urandom, $urandom} | 64'h8000_8000_8000_8000;
        default: word = {$urandom, $urandom};
      endcase
      send_frame(ch, word);
    end
  endtask

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: nothing here may produce a cell.
    // Every idle pattern on a live channel still advances its counter.
    for (int i = 0; i < 7; i++) send_frame(7'd6, idle_pattern(i));
    // crossing would go negative under the reset latencies
    send_frame(7'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    // channel below the skip, then a frame inside the leading skip
    send_frame(7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(7'd8, 64'h0123_4567_89AB_CDEF);
    send_frame(7'd127, 64'h7FFF_7FFF_7FFF_7FFF);

    // No skips, no latency: walk an even channel through all eight phases, so every even
    // channel slot, the dropped high columns and the phases with no module show up
    load_settings(0, 0, 0, 0, 0, 1'b1);
    for (int i = 0; i < 8; i++)
      send_frame(7'd2, (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                       (i == 1) ? 64'h8000_8000_8000_8000 : {$urandom, $urandom});
    // odd channel: phase zero gives the odd super cell, the next phase nothing
    send_frame(7'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(7'd3, {$urandom, $urandom});

    // Random part over several settings, extremes first
    load_settings(0, 0, 0, 0, 0, 1'b0);
    random_phase(30, 1'b0);
    load_settings(15, 127, 255, 255, 255, 1'b0);
    random_phase(20, 1'b0);
    load_settings($urandom_range(0, 15), $urandom_range(0, 6), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 3), 1'b1);
    random_phase(35, 1'b1);
    load_settings($urandom_range(0, 15), $urandom_range(0, 6), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 3), 1'b0);
    random_phase(35, 1'b0);
    // last stretch at full rate on both sides
    idle_enabled <= 1'b0;
    load_settings($urandom_range(0, 15), $urandom_range(0, 6), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 3), 1'b0);
    random_phase(40, 1'b0);
    settle();

    $display("summary: %0d frames in, %0d cells checked over %0d register settings",
             tracker.frames_noted, tracker.cells_checked, settings_used);
    $display("summary: idle and skipped frames, all slots and phases, late crossings");
    if (tracker.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/tcfu_pkg.sv
src/tcfu_count_ram.sv
src/tcfu_cell_emit.sv
src/trigger_cell_frame_unpacker.sv
sim/testbench.sv
